@@ rtl/prime_range_lister_macros.svh @@
// Assertion macros shared by the prime range lister RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PRIME_RANGE_LISTER_MACROS_SVH
`define PRIME_RANGE_LISTER_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define PRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prl: assertion failed");

// Next-cycle implication, gated by the active-low reset.
`define PRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prl: assertion failed");

`endif

@@ rtl/prl_pkg.sv @@
// Shared types and constants for the prime range lister.
// No dependencies; imported by the interfaces and all RTL modules.
package prl_pkg;

    localparam int FIELD_BITS  = 16;  // width of the bound and prime fields
    localparam int FIRST_DIV   = 2;   // first trial divisor
    localparam int FIRST_SQ    = 4;   // its square
    localparam int MIN_CAND    = 2;   // lowest candidate ever tested

    // Status returned by the remainder unit
    typedef struct packed {
        logic done;      // one-cycle pulse when the remainder is ready
        logic rem_zero;  // remainder is zero (valid with done)
    } t_mod_status;

endpackage

@@ rtl/prl_if.sv @@
// Valid/ready channel interfaces for the prime range lister.
// Depends on prl_pkg for the field width.
interface prl_req_if;
    import prl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] range_low;
    logic [FIELD_BITS-1:0] range_high;

    modport source (output valid, range_low, range_high, input ready);
    modport sink   (input valid, range_low, range_high, output ready);
endinterface

interface prl_res_if;
    import prl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] prime_value;
    logic                  last_result;
    logic                  range_empty;
    logic                  list_truncated;

    modport source (output valid, prime_value, last_result, range_empty, list_truncated,
                    input ready);
    modport sink   (input valid, prime_value, last_result, range_empty, list_truncated,
                    output ready);
endinterface

@@ rtl/prl_mod_unit.sv @@
// Restoring remainder unit: dividend mod divisor, one bit per cycle.
// Depends on prl_pkg (t_mod_status).
module prl_mod_unit #(
    parameter int VALUE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [VALUE_BITS-1:0]   i_dividend,
    input  logic [VALUE_BITS-1:0]   i_divisor,
    output prl_pkg::t_mod_status    o_status
);
    import prl_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [VALUE_BITS-1:0] r_rem;

    logic [VALUE_BITS:0]   rem_sh;
    logic [VALUE_BITS:0]   rem_sub;
    logic                  fits;

    // divisor is held steady by the caller for the whole operation
    always_comb begin
        rem_sh  = {r_rem, r_shift[VALUE_BITS-1]};
        rem_sub = rem_sh - {1'b0, i_divisor};
        fits    = rem_sh >= {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CNT_W'(VALUE_BITS);
                r_shift <= i_dividend;
                r_rem   <= '0;
            end else if (r_busy) begin
                r_rem   <= fits ? rem_sub[VALUE_BITS-1:0] : rem_sh[VALUE_BITS-1:0];
                r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

@@ rtl/prime_range_lister.sv @@
// Prime range lister: trial-division search, one divisor test at a time.
// For candidate n the trial divisors run from 2 up to floor(sqrt(n)), stopping at
// the first divisor found; each is tested by the bit-serial remainder unit.
// A request steps through all its candidates; one request at a time, i_req.ready
// is high only between requests.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
module prime_range_lister #(
    parameter int VALUE_BITS     = 16,
    parameter int MAX_PRIMES_OUT = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prl_req_if.sink   i_req,
    prl_res_if.source o_res
);
    import prl_pkg::*;

    `include "prime_range_lister_macros.svh"

    localparam int CNT_W = $clog2(MAX_PRIMES_OUT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_TEST,
        S_DIV,
        S_FOUND,
        S_NEXT,
        S_FLUSH
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_cand;
    logic [VALUE_BITS-1:0] r_hi;
    logic [VALUE_BITS-1:0] r_div;
    logic [VALUE_BITS:0]   r_sq;
    logic [VALUE_BITS-1:0] r_pend;
    logic                  r_has_pend;
    logic [CNT_W-1:0]      r_count;
    logic                  r_mod_start;

    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_out_value;
    logic                  r_out_last;
    logic                  r_out_empty;
    logic                  r_out_trunc;

    t_mod_status           mod_status;
    logic                  out_free;
    logic [VALUE_BITS-1:0] lo_in;
    logic [VALUE_BITS-1:0] hi_in;
    logic [VALUE_BITS:0]   cand_ext;

    always_comb begin
        out_free = !r_out_valid || o_res.ready;
        lo_in    = VALUE_BITS'(i_req.range_low);
        hi_in    = VALUE_BITS'(i_req.range_high);
        cand_ext = {1'b0, r_cand};
    end

    prl_mod_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mod_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_status   (mod_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_has_pend  <= 1'b0;
            r_count     <= '0;
            r_mod_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mod_start <= 1'b0;
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cand     <= (lo_in < VALUE_BITS'(MIN_CAND)) ?
                                      VALUE_BITS'(MIN_CAND) : lo_in;
                        r_hi       <= hi_in;
                        r_has_pend <= 1'b0;
                        r_count    <= '0;
                        r_state    <= S_START;
                    end
                end
                S_START: begin
                    r_div <= VALUE_BITS'(FIRST_DIV);
                    r_sq  <= (VALUE_BITS + 1)'(FIRST_SQ);
                    if (r_cand > r_hi) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_sq > cand_ext) begin
                        r_state <= S_FOUND;
                    end else begin
                        r_mod_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (mod_status.done) begin
                        if (mod_status.rem_zero) begin
                            r_state <= S_NEXT;
                        end else begin
                            // (d+1)^2 = d^2 + 2d + 1
                            r_sq    <= r_sq + {r_div, 1'b1};
                            r_div   <= r_div + VALUE_BITS'(1);
                            r_state <= S_TEST;
                        end
                    end
                end
                S_FOUND: begin
                    // the held prime is not the last one: release it first
                    if (r_has_pend) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= FIELD_BITS'(r_pend);
                            r_out_last  <= 1'b0;
                            r_out_empty <= 1'b0;
                            r_out_trunc <= 1'b0;
                            r_has_pend  <= 1'b0;
                        end
                    end else if (r_count == CNT_W'(MAX_PRIMES_OUT - 1)) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= FIELD_BITS'(r_cand);
                            r_out_last  <= 1'b1;
                            r_out_empty <= 1'b0;
                            r_out_trunc <= (r_cand != r_hi);
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_pend     <= r_cand;
                        r_has_pend <= 1'b1;
                        r_count    <= r_count + CNT_W'(1);
                        r_state    <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_div <= VALUE_BITS'(FIRST_DIV);
                    r_sq  <= (VALUE_BITS + 1)'(FIRST_SQ);
                    if (r_cand == r_hi) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_cand  <= r_cand + VALUE_BITS'(1);
                        r_state <= S_TEST;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_has_pend ? FIELD_BITS'(r_pend) : '0;
                        r_out_last  <= 1'b1;
                        r_out_empty <= !r_has_pend;
                        r_out_trunc <= 1'b0;
                        r_has_pend  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.prime_value    = r_out_value;
    assign o_res.last_result    = r_out_last;
    assign o_res.range_empty    = r_out_empty;
    assign o_res.list_truncated = r_out_trunc;

    logic sq_in_range;
    logic empty_ok;
    logic count_ok;
    logic flush_done;

    always_comb begin
        sq_in_range = (r_sq <= cand_ext);
        empty_ok    = (r_out_value == '0) && r_out_last && !r_out_trunc;
        count_ok    = (r_count < CNT_W'(MAX_PRIMES_OUT));
        flush_done  = (r_state == S_IDLE) && r_out_valid && r_out_last;
    end

    `PRL_ASSERT_IMP(a_div_only_below_root, i_clk, i_rst_n, r_state == S_DIV, sq_in_range)
    `PRL_ASSERT_IMP(a_empty_result_form, i_clk, i_rst_n, r_out_valid && r_out_empty, empty_ok)
    `PRL_ASSERT_IMP(a_count_bounded, i_clk, i_rst_n, 1'b1, count_ok)
    `PRL_ASSERT_NXT(a_flush_ends_item, i_clk, i_rst_n, r_state == S_FLUSH && out_free, flush_done)

endmodule

@@ sim/tb_top.sv @@
// Testbench for prime_range_lister: range requests in, primes checked against a local predictor.
// Depends on prl_pkg and the prl_req_if / prl_res_if interfaces from the RTL.
module tb_top;
    import prl_pkg::*;

    localparam int MAX_PRIMES   = 64;
    localparam int DRAIN_CYCLES = 6000;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic                  last;
        logic                  empty;
        logic                  trunc;
    } prime_res_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    prl_req_if req_ch ();
    prl_res_if res_ch ();

    prime_range_lister #(
        .VALUE_BITS     (FIELD_BITS),
        .MAX_PRIMES_OUT (MAX_PRIMES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    prime_res_t expected_primes[$];
    int         error_count   = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_off_len  = 0;
    int         hold_off_id   = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.range_low  = '0;
        req_ch.range_high = '0;
        res_ch.ready      = 1'b0;
    end

    // Result side readiness; a long hold-off is requested by bumping hold_off_id
    always @(negedge i_clk) begin
        static int stall_left = 0;
        static int seen_id    = 0;
        if (hold_off_id != seen_id) begin
            seen_id    = hold_off_id;
            stall_left = hold_off_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic bit prime_check(input int unsigned n);
        int unsigned d;
        if (n < MIN_CAND) return 1'b0;
        for (d = FIRST_DIV; d * d <= n; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_primes(input logic [FIELD_BITS-1:0] lo_in,
                                  input logic [FIELD_BITS-1:0] hi_in);
        int unsigned cand;
        int unsigned lo;
        int unsigned hi;
        int          found;
        prime_res_t  r;
        lo    = (lo_in < MIN_CAND) ? MIN_CAND : lo_in;
        hi    = hi_in;
        found = 0;
        for (cand = lo; cand <= hi && found < MAX_PRIMES; cand++) begin
            if (prime_check(cand)) begin
                if (found > 0) expected_primes[expected_primes.size() - 1].last = 1'b0;
                r = '{value: cand[FIELD_BITS-1:0], last: 1'b1, empty: 1'b0, trunc: 1'b0};
                found++;
                // stopped at the limit with candidates left untested
                if (found == MAX_PRIMES && cand < hi) r.trunc = 1'b1;
                expected_primes.push_back(r);
            end
        end
        if (found == 0) begin
            r = '{value: '0, last: 1'b1, empty: 1'b1, trunc: 1'b0};
            expected_primes.push_back(r);
        end
    endtask

    // Offers one request and returns once it is accepted; valid is left high
    task automatic send_range(input int unsigned lo, input int unsigned hi);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid      = 1'b1;
        req_ch.range_low  = lo[FIELD_BITS-1:0];
        req_ch.range_high = hi[FIELD_BITS-1:0];
        do @(posedge i_clk); while (!req_ch.ready);
        predict_primes(lo[FIELD_BITS-1:0], hi[FIELD_BITS-1:0]);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        prime_res_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_primes.size() == 0) begin
                $display("%0t: unexpected item: value %0d last %b empty %b trunc %b", $time,
                         res_ch.prime_value, res_ch.last_result, res_ch.range_empty,
                         res_ch.list_truncated);
                error_count++;
            end else begin
                want = expected_primes.pop_front();
                if (res_ch.prime_value !== want.value) begin
                    $display("%0t: prime_value expected %0d actual %0d", $time,
                             want.value, res_ch.prime_value);
                    error_count++;
                end
                if (res_ch.last_result !== want.last) begin
                    $display("%0t: last_result expected %b actual %b (value %0d)", $time,
                             want.last, res_ch.last_result, want.value);
                    error_count++;
                end
                if (res_ch.range_empty !== want.empty) begin
                    $display("%0t: range_empty expected %b actual %b (value %0d)", $time,
                             want.empty, res_ch.range_empty, want.value);
                    error_count++;
                end
                if (res_ch.list_truncated !== want.trunc) begin
                    $display("%0t: list_truncated expected %b actual %b (value %0d)", $time,
                             want.trunc, res_ch.list_truncated, want.value);
                    error_count++;
                end
            end
        end
    end

    task automatic test_bounds();
        send_range(0, 0);
        send_range(0, 1);
        send_range(1, 2);
        send_range(0, 2);
        send_range(2, 2);
        send_range(3, 3);
        send_range(4, 4);
        send_range(65535, 65535);
        send_range(65521, 65535);  // top of the range, largest 16-bit prime
    endtask

    task automatic test_empty_ranges();
        send_range(65535, 0);
        send_range(100, 50);
        send_range(24, 28);
        send_range(90, 96);
    endtask

    task automatic test_limit();
        send_range(0, 311);    // exactly the limit, ending on the bound
        send_range(0, 312);    // limit reached, one composite left untested
        send_range(0, 65535);
    endtask

    // Long result hold-off while requests keep coming, so the input backs up
    task automatic test_back_pressure();
        @(posedge i_clk);
        hold_off_len = 5000;
        hold_off_id++;
        send_range(2, 30);
        send_range(100, 130);
        send_range(200, 220);
        send_range(0, 0);
    endtask

    task automatic test_random(input int n_items);
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                lo = $urandom_range(300);
                hi = lo + $urandom_range(40);
            end else if (pick < 84) begin
                lo = $urandom_range(65535);
                hi = lo + $urandom_range(3);
                if (hi > 65535) hi = 65535;
            end else if (pick < 96) begin
                lo = $urandom_range(65535, 1);
                hi = $urandom_range(lo - 1);
            end else begin
                lo = $urandom_range(20);
                hi = $urandom_range(65535, 300);
            end
            send_range(lo, hi);
        end
    endtask

    task automatic wait_drained();
        while (expected_primes.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 12;
        recv_idle_pct = 75;
        test_bounds();
        test_empty_ranges();
        test_limit();
        test_back_pressure();
        test_random(34);

        send_idle_pct = 75;
        recv_idle_pct = 12;
        test_random(33);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(33);

        stop_sending();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_primes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
